/* rtl/http_name_value_parser_core_assert.svh */
// ---------------------------------------------------------------------------
// HTTP name/value parser assertion macros
// Clocked assertion shorthands for the parser RTL.
// ---------------------------------------------------------------------------
`ifndef HTTP_NAME_VALUE_PARSER_CORE_ASSERT_SVH
`define HTTP_NAME_VALUE_PARSER_CORE_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define HNVP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HNVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/hnvp_pkg.sv */
// ---------------------------------------------------------------------------
// HTTP name/value parser package
// Shared types, constants and character class functions.
// ---------------------------------------------------------------------------
package hnvp_pkg;

  localparam int unsigned CONSUMED_W  = 16;
  localparam int unsigned MAX_LEN_DEF = 65535;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic REG_LENIENT_VALUE = 1'b0;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_VALUE   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
    logic       is_tok;
    logic       is_sp;
    logic       is_txt;
    logic       val_ok;
    logic       is_eq;
    logic       is_quote;
    logic       is_bslash;
  } entry_t;

  typedef struct packed {
    logic [1:0]            out_kind;
    logic [7:0]            out_byte;
    logic [CONSUMED_W-1:0] consumed;
    logic                  name_found;
    logic                  equals_seen;
    logic                  value_quoted;
    logic                  run_last;
  } res_t;

  function automatic logic is_separator(input logic [7:0] c);
    logic r;
    case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
      8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return (c > CH_SPACE) && (c < CH_DEL) && !is_separator(c);
  endfunction

  // Extra characters allowed in a lenient unquoted value.
  function automatic logic is_lenient_extra(input logic [7:0] c);
    logic r;
    case (c)
      8'h5B, 8'h5D, 8'h20, 8'h2C, 8'h28, 8'h29, 8'h3D, 8'h2F, 8'h3A,
      8'h40, 8'h3C, 8'h3E, 8'h7B, 8'h7D, 8'h3F: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/hnvp_in_if.sv */
// ---------------------------------------------------------------------------
// HTTP name/value parser input channel
// Valid/ready stream carrying one header byte per transaction.
// ---------------------------------------------------------------------------
interface hnvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       empty_string;

  modport source (output valid, in_byte, in_last, empty_string, input ready);
  modport sink (input valid, in_byte, in_last, empty_string, output ready);
endinterface

/* rtl/hnvp_out_if.sv */
// ---------------------------------------------------------------------------
// HTTP name/value parser output channel
// Valid/ready stream carrying name bytes, value bytes and end summaries.
// ---------------------------------------------------------------------------
interface hnvp_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      out_kind;
  logic [7:0]                      out_byte;
  logic [hnvp_pkg::CONSUMED_W-1:0] consumed;
  logic                            name_found;
  logic                            equals_seen;
  logic                            value_quoted;
  logic                            run_last;

  modport source (output valid, out_kind, out_byte, consumed, name_found, equals_seen,
                  value_quoted, run_last, input ready);
  modport sink (input valid, out_kind, out_byte, consumed, name_found, equals_seen,
                value_quoted, run_last, output ready);
endinterface

/* rtl/hnvp_front.sv */
// ---------------------------------------------------------------------------
// HTTP name/value parser front end
// Accepts input transactions and tags each byte with its character classes.
// ---------------------------------------------------------------------------
module hnvp_front (
  input  logic                lenient,
  hnvp_in_if.sink             in_ch,
  output logic                push_valid,
  output hnvp_pkg::entry_t    push_data,
  input  logic                push_ready
);

  logic [7:0] c;
  logic       tok;

  assign c   = in_ch.in_byte;
  assign tok = hnvp_pkg::is_token(c);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_data.data      = c;
    push_data.last      = in_ch.in_last;
    push_data.empty     = in_ch.empty_string;
    push_data.is_tok    = tok;
    push_data.is_sp     = (c <= hnvp_pkg::CH_SPACE);
    push_data.is_txt    = (c >= hnvp_pkg::CH_SPACE) && (c != hnvp_pkg::CH_DEL);
    push_data.val_ok    = tok || (lenient && hnvp_pkg::is_lenient_extra(c));
    push_data.is_eq     = (c == hnvp_pkg::CH_EQ);
    push_data.is_quote  = (c == hnvp_pkg::CH_QUOTE);
    push_data.is_bslash = (c == hnvp_pkg::CH_BSLASH);
  end

endmodule

/* rtl/hnvp_queue.sv */
// ---------------------------------------------------------------------------
// HTTP name/value parser queue
// Small register FIFO decoupling the classifier from the parse engine.
// ---------------------------------------------------------------------------
module hnvp_queue #(
  parameter int unsigned DEPTH = hnvp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  hnvp_pkg::entry_t push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output hnvp_pkg::entry_t pop_data,
  input  logic             pop_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hnvp_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/hnvp_back.sv */
// ---------------------------------------------------------------------------
// HTTP name/value parser engine
// Runs the name/'='/value phase machine and buffers up to two results.
// ---------------------------------------------------------------------------
`include "http_name_value_parser_core_assert.svh"

module hnvp_back #(
  parameter int unsigned MAX_LEN = hnvp_pkg::MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  input  hnvp_pkg::entry_t pop_data,
  output logic             pop_ready,
  hnvp_out_if.source       out_ch
);

  localparam int unsigned CW = hnvp_pkg::CONSUMED_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

  localparam logic [2:0] PH_NAME      = 3'd0;
  localparam logic [2:0] PH_WS_BEFORE = 3'd1;
  localparam logic [2:0] PH_WS_AFTER  = 3'd2;
  localparam logic [2:0] PH_TOKEN     = 3'd3;
  localparam logic [2:0] PH_QUOTED    = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  logic [2:0]    phase, phase_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          esc, esc_next;
  logic [2:0]    flags, flags_next;

  hnvp_pkg::res_t ob [2];
  logic [1:0]     ob_cnt;

  hnvp_pkg::entry_t e;
  hnvp_pkg::res_t   r0, r1, sum_res;
  logic             emit, taken, fin, drain, pop;
  logic [1:0]       ekind;
  logic [1:0]       n_res;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v < MAX_CNT) ? v + 1'b1 : v;
  endfunction

  assign e     = pop_data;
  assign drain = out_ch.valid && out_ch.ready;
  assign pop_ready = (ob_cnt == 2'd0) || ((ob_cnt == 2'd1) && drain);
  assign pop   = pop_valid && pop_ready;

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    esc_next   = esc;
    flags_next = flags;
    emit       = 1'b0;
    taken      = 1'b0;
    ekind      = hnvp_pkg::KIND_NAME;
    fin        = e.empty || e.last;

    if (!e.empty) begin
      if (phase_next == PH_NAME) begin
        if (e.is_tok) begin
          flags_next[0] = 1'b1;
          cnt_next      = sat_inc(cnt_next);
          emit          = 1'b1;
          taken         = 1'b1;
        end else if (!flags_next[0]) begin
          phase_next = PH_DONE;
          taken      = 1'b1;
        end else begin
          phase_next = PH_WS_BEFORE;
        end
      end
      if (!taken && phase_next == PH_WS_BEFORE) begin
        taken = 1'b1;
        if (e.is_sp) begin
          cnt_next = sat_inc(cnt_next);
        end else if (e.is_eq) begin
          cnt_next      = sat_inc(cnt_next);
          flags_next[1] = 1'b1;
          phase_next    = PH_WS_AFTER;
        end else begin
          phase_next = PH_DONE;
        end
      end
      if (!taken && phase_next == PH_WS_AFTER) begin
        if (e.is_sp) begin
          cnt_next = sat_inc(cnt_next);
          taken    = 1'b1;
        end else if (e.is_quote) begin
          cnt_next      = sat_inc(cnt_next);
          flags_next[2] = 1'b1;
          phase_next    = PH_QUOTED;
          taken         = 1'b1;
        end else begin
          phase_next = PH_TOKEN;
        end
      end
      if (!taken && phase_next == PH_TOKEN) begin
        taken = 1'b1;
        if (e.val_ok) begin
          cnt_next = sat_inc(cnt_next);
          emit     = 1'b1;
          ekind    = hnvp_pkg::KIND_VALUE;
        end else begin
          phase_next = PH_DONE;
        end
      end
      if (!taken && phase_next == PH_QUOTED) begin
        cnt_next = sat_inc(cnt_next);
        ekind    = hnvp_pkg::KIND_VALUE;
        if (esc_next) begin
          esc_next = 1'b0;
          emit     = 1'b1;
        end else if (e.is_bslash) begin
          esc_next = 1'b1;
        end else if (e.is_quote) begin
          phase_next = PH_DONE;
        end else if (e.is_txt) begin
          emit = 1'b1;
        end
      end
    end

    sum_res.out_kind     = hnvp_pkg::KIND_SUMMARY;
    sum_res.out_byte     = '0;
    sum_res.consumed     = cnt_next;
    sum_res.name_found   = flags_next[0];
    sum_res.equals_seen  = flags_next[1];
    sum_res.value_quoted = flags_next[2];
    sum_res.run_last     = 1'b1;

    r0.out_kind     = ekind;
    r0.out_byte     = e.data;
    r0.consumed     = '0;
    r0.name_found   = 1'b0;
    r0.equals_seen  = 1'b0;
    r0.value_quoted = 1'b0;
    r0.run_last     = 1'b0;
    if (!emit) begin
      r0 = sum_res;
    end
    r1    = sum_res;
    n_res = {1'b0, emit} + {1'b0, fin};

    if (fin) begin
      phase_next = PH_NAME;
      cnt_next   = '0;
      esc_next   = 1'b0;
      flags_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_NAME;
      cnt    <= '0;
      esc    <= 1'b0;
      flags  <= '0;
      ob_cnt <= '0;
    end else begin
      if (pop) begin
        phase  <= phase_next;
        cnt    <= cnt_next;
        esc    <= esc_next;
        flags  <= flags_next;
        ob_cnt <= n_res;
      end else if (drain) begin
        ob_cnt <= ob_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ob[0] <= r0;
      ob[1] <= r1;
    end else if (drain) begin
      ob[0] <= ob[1];
    end
  end

  assign out_ch.valid        = (ob_cnt != 2'd0);
  assign out_ch.out_kind     = ob[0].out_kind;
  assign out_ch.out_byte     = ob[0].out_byte;
  assign out_ch.consumed     = ob[0].consumed;
  assign out_ch.name_found   = ob[0].name_found;
  assign out_ch.equals_seen  = ob[0].equals_seen;
  assign out_ch.value_quoted = ob[0].value_quoted;
  assign out_ch.run_last     = ob[0].run_last;

  `HNVP_ASSERT_ALWAYS(a_ob_cnt_range, ob_cnt != 2'd3, "result buffer overfilled")
  `HNVP_ASSERT_ALWAYS(a_esc_in_quoted, !esc || (phase == PH_QUOTED), "escape outside quoted value")
  `HNVP_ASSERT_NEXT(a_clear_after_end, pop && fin, (phase == PH_NAME) && (cnt == '0) && (flags == '0), "state not cleared after summary")
  `HNVP_ASSERT_NEXT(a_two_results, pop && (n_res == 2'd2), (ob_cnt == 2'd2) && ob[1].run_last && !ob[0].run_last, "byte and summary misordered")

endmodule

/* rtl/http_name_value_parser_core.sv */
// ---------------------------------------------------------------------------
// HTTP name/value parser core
// Parses one name=value pair from a header string, one byte per transaction.
// ---------------------------------------------------------------------------
// in_ch carries the header bytes; in_last marks the final byte, and a
// transaction with empty_string set closes the string without a byte.
// out_ch returns name bytes (kind 0), value bytes (kind 1) and, for the
// final transaction of each string, an end summary (kind 2) with the
// consumed length and the name, '=' and quoting flags.
// Throughput is one byte per cycle while out_ch accepts results; a byte
// that is emitted and also ends the string yields two results, and the
// engine stops popping until the first drains from the single output port
// of the two-entry result buffer. A byte is registered in the queue by the
// classifier and then in the result buffer by the engine.
// The APB register at offset 0 holds lenient_value; write it only while
// the core is idle.
// Reset clears the queue, the result buffer, the parse state and the
// register. When out_ch stalls, the result buffer fills, the engine stops
// popping and the queue then holds in_ch.ready low.
// ---------------------------------------------------------------------------
module http_name_value_parser_core #(
  parameter int unsigned MAX_LEN = hnvp_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  hnvp_in_if.sink                      in_ch,
  hnvp_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hnvp_pkg::PADDR_W-1:0] paddr,
  input  logic [hnvp_pkg::PDATA_W-1:0] pwdata,
  output logic [hnvp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  logic             lenient;
  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  hnvp_pkg::entry_t push_data, pop_data;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[hnvp_pkg::PADDR_W-1] == hnvp_pkg::REG_LENIENT_VALUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lenient <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      lenient <= pwdata[0];
    end
  end

  assign prdata = reg_hit ? {{(hnvp_pkg::PDATA_W-1){1'b0}}, lenient} : '0;

  hnvp_front u_front (
    .lenient    (lenient),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  hnvp_queue #(
    .DEPTH (hnvp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  hnvp_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
